/* rtl/dpr_pkg.sv */
`timescale 1ns / 1ps

package dpr_pkg;

    localparam int WEIGHT_W = 16;
    localparam int IDX_W    = 6;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* rtl/dpr_if.sv */
`timescale 1ns / 1ps

interface dpr_in_if;
    import dpr_pkg::*;

    logic                valid;
    logic                ready;
    logic [WEIGHT_W-1:0] weight;
    logic                final_weight;

    modport source (output valid, output weight, output final_weight, input ready);
    modport sink   (input valid, input weight, input final_weight, output ready);
endinterface

interface dpr_out_if;
    import dpr_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] particle_index;
    logic             final_index;
    logic             zero_total;

    modport source (output valid, output particle_index, output final_index,
                    output zero_total, input ready);
    modport sink   (input valid, input particle_index, input final_index,
                    input zero_total, output ready);
endinterface

/* rtl/deterministic_particle_resampler.sv */
`timescale 1ns / 1ps

// channel  | dir | beat fields
// ---------+-----+-------------------------------------------
// i_wt     | in  | weight[15:0], final_weight
// o_res    | out | particle_index[5:0], final_index, zero_total
//
// loading takes one weight per cycle; the weights sit in a one-port-read ram
// the walk does per weight a ram read, a start step, the restoring divide, an emit
// step for each emitted index and a step to leave the emit state, and the fraction
// step; padding repeats the last index until as many indices as weights are out;
// an all-zero set emits a single zero_total beat
// i_wt.ready is low from the final weight until the walk is back in load, which
// it enters from the pad state (for an all-zero set, on the edge the zero-total beat
// enters the output register); a stalled o_res holds the walk
// synchronous active-low reset; no clearing pass, stored weights are unreset

module deterministic_particle_resampler #(
    parameter int MAX_PARTICLES = 64,
    parameter int FRAC_BITS     = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dpr_in_if.sink     i_wt,
    dpr_out_if.source  o_res
);
    import dpr_pkg::*;

    localparam int AW = $clog2(MAX_PARTICLES);
    localparam int CW = $clog2(MAX_PARTICLES + 1);
    localparam int TW = WEIGHT_W + AW;
    localparam int PW = WEIGHT_W + CW;
    localparam int QW = FRAC_BITS + CW;
    localparam logic [FRAC_BITS:0] HALF = (FRAC_BITS + 1)'(1) << (FRAC_BITS - 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_ZERO,
        S_READ,
        S_START,
        S_DIV,
        S_EMIT,
        S_FRAC,
        S_PAD
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic [TW-1:0]      r_total;
    logic [FRAC_BITS:0] r_acc;
    logic [CW-1:0]      r_emitted;
    logic [AW-1:0]      r_idx;
    logic [CW-1:0]      r_whole;
    logic [FRAC_BITS-1:0] r_frac;
    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_idx;
    logic               r_out_fin;
    logic               r_out_zero;

    logic               in_acc;
    logic               room;
    logic [CW-1:0]      n_count;
    logic [TW-1:0]      n_total;
    logic               ram_we;
    logic [WEIGHT_W-1:0] ram_rdata;
    logic               slot;
    logic               left;
    logic               last_emit;
    logic               idx_last;
    logic [FRAC_BITS:0] acc_sum;
    logic               div_start;
    logic [PW-1:0]      prod;
    t_div_stat          div_stat;
    logic [QW-1:0]      quot;

    assign i_wt.ready = (r_state == S_LOAD);
    assign in_acc     = i_wt.valid && i_wt.ready;
    assign room       = r_count < CW'(MAX_PARTICLES);
    assign n_count    = room ? CW'(r_count + 1'b1) : r_count;
    assign n_total    = room ? TW'(r_total + TW'(i_wt.weight)) : r_total;
    assign ram_we     = in_acc && room;

    assign slot      = !r_out_valid || o_res.ready;
    assign left      = r_emitted < r_count;
    assign last_emit = CW'(r_emitted + 1'b1) == r_count;
    assign idx_last  = CW'(CW'(r_idx) + 1'b1) >= r_count;
    assign acc_sum   = r_acc + {1'b0, r_frac};

    assign div_start = (r_state == S_START);
    assign prod      = PW'(ram_rdata) * PW'(r_count);

    dpr_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (MAX_PARTICLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_wt.weight),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    dpr_div #(
        .FRAC_BITS (FRAC_BITS),
        .CW        (CW),
        .TW        (TW),
        .PW        (PW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_prod  (prod),
        .i_total (r_total),
        .o_stat  (div_stat),
        .o_quot  (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_total     <= '0;
            r_acc       <= HALF;
            r_emitted   <= '0;
            r_idx       <= '0;
            r_whole     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        r_count <= n_count;
                        r_total <= n_total;
                        if (i_wt.final_weight) begin
                            r_idx     <= '0;
                            r_emitted <= '0;
                            r_acc     <= HALF;
                            r_state   <= (n_total == '0) ? S_ZERO : S_READ;
                        end
                    end
                end
                S_ZERO: begin
                    if (slot) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= '0;
                        r_out_fin   <= 1'b1;
                        r_out_zero  <= 1'b1;
                        r_count     <= '0;
                        r_total     <= '0;
                        r_state     <= S_LOAD;
                    end
                end
                S_READ: begin
                    r_state <= S_START;
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_whole <= quot[QW-1:FRAC_BITS];
                        r_frac  <= quot[FRAC_BITS-1:0];
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (r_whole == '0 || !left) begin
                        r_state <= S_FRAC;
                    end else if (slot) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= IDX_W'(r_idx);
                        r_out_fin   <= last_emit;
                        r_out_zero  <= 1'b0;
                        r_emitted   <= CW'(r_emitted + 1'b1);
                        r_whole     <= CW'(r_whole - 1'b1);
                    end
                end
                S_FRAC: begin
                    if (!acc_sum[FRAC_BITS] || !left || slot) begin
                        if (acc_sum[FRAC_BITS] && left) begin
                            r_out_valid <= 1'b1;
                            r_out_idx   <= IDX_W'(r_idx);
                            r_out_fin   <= last_emit;
                            r_out_zero  <= 1'b0;
                            r_emitted   <= CW'(r_emitted + 1'b1);
                        end
                        r_acc <= {1'b0, acc_sum[FRAC_BITS-1:0]};
                        if (idx_last) begin
                            r_state <= S_PAD;
                        end else begin
                            r_idx   <= AW'(r_idx + 1'b1);
                            r_state <= S_READ;
                        end
                    end
                end
                S_PAD: begin
                    if (!left) begin
                        r_count   <= '0;
                        r_total   <= '0;
                        r_emitted <= '0;
                        r_acc     <= HALF;
                        r_state   <= S_LOAD;
                    end else if (slot) begin
                        // rounding shortfall, repeat the last index
                        r_out_valid <= 1'b1;
                        r_out_idx   <= IDX_W'(CW'(r_count - 1'b1));
                        r_out_fin   <= last_emit;
                        r_out_zero  <= 1'b0;
                        r_emitted   <= CW'(r_emitted + 1'b1);
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.particle_index = r_out_idx;
    assign o_res.final_index    = r_out_fin;
    assign o_res.zero_total     = r_out_zero;

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emitted <= r_count)
        else $error("more indices emitted than weights loaded");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_zero_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.zero_total |-> o_res.final_index)
        else $error("zero-total beat not marked final");

    a_whole_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_whole <= r_count)
        else $error("share exceeds set size");

endmodule

/* rtl/dpr_ram.sv */
`timescale 1ns / 1ps

module dpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/dpr_div.sv */
`timescale 1ns / 1ps

module dpr_div #(
    parameter int FRAC_BITS = 16,
    parameter int CW        = 7,
    parameter int TW        = 22,
    parameter int PW        = 23
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [PW-1:0]             i_prod,
    input  logic [TW-1:0]             i_total,
    output dpr_pkg::t_div_stat        o_stat,
    output logic [FRAC_BITS+CW-1:0]   o_quot
);
    import dpr_pkg::*;

    localparam int QW  = FRAC_BITS + CW;
    localparam int QCW = $clog2(QW + 1);

    logic [TW-1:0]  r_rem;
    logic [QW-1:0]  r_q;
    logic [QCW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [TW:0]    rem2;
    logic           ge;

    // one quotient bit per cycle, restoring
    assign rem2 = {r_rem, r_q[QW-1]};
    assign ge   = rem2 >= {1'b0, i_total};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= TW'(i_prod >> CW);
                r_q    <= {i_prod[CW-1:0], {FRAC_BITS{1'b0}}};
                r_cnt  <= QCW'(QW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? TW'(rem2 - {1'b0, i_total}) : TW'(rem2);
                r_q   <= {r_q[QW-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == QCW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_q;

endmodule
